/* sv/wsrr_pkg.sv */
// shared types, constants and handshake structs for the work slot dispatcher
package wsrr_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int TS_W      = 40;
  localparam int DOM_W     = 5;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = TS_W;

  // input word layout
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_DOM_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_TS_LSB   = IN_DOM_LSB + DOM_W;
  localparam int IN_BITS     = IN_TS_LSB + TS_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // output word layout
  localparam int OUT_SLOT_LSB = 0;
  localparam int OUT_STS_LSB  = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_CNT_LSB  = OUT_STS_LSB + STATUS_W;
  localparam int OUT_BITS     = OUT_CNT_LSB + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_REG   = 2'd0,
    MODE_ADV   = 2'd1,
    MODE_CLAIM = 2'd2,
    MODE_REL   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_WORK = 2'd1,
    ST_ALREADY = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN = 2'd1;

  typedef struct packed {
    logic signed [DOM_W-1:0] dom;
    logic [TS_W-1:0]         ts;
  } slot_entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic rd_en;
    logic claim_hit;
    logic claim_miss;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  out_free;
    logic  scan_end;
    logic  slot_live;
    logic  slot_ok;
  } dp_sts_t;

endpackage

/* sv/work_slot_round_robin_dispatcher_top.sv */
// top level of the work slot round-robin dispatcher
//
// The block keeps a table of 64 work slots and answers every input word with
// exactly one result word. Register, advertise and release words are captured,
// then executed once the output register is free. A claim word starts a
// circular scan that steps past each visited slot that is not both registered
// and active, and reads and checks each one that is, until a slot qualifies or
// the scan has visited every assigned slot without a match. The scan walks the
// slot table one slot at a time through its single registered read port. A new
// input word is taken in the cycle after the previous result is written to the
// output register, even while that result still waits on tready. Configuration
// writes are always ready and land in the configuration registers.
module work_slot_round_robin_dispatcher_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // slot[5:0], item_domain[10:6], item_min_timeslice[50:11], zero fill
  input  logic [wsrr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // mode[1:0]
  input  logic [wsrr_pkg::MODE_W-1:0]           s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // result_slot[5:0], status[7:6], active_count[14:8], zero fill
  output logic [wsrr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wsrr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wsrr_pkg::CFG_DAT_W-1:0]        cfg_data_i
);
  import wsrr_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  wsrr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  wsrr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mode_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* sv/wsrr_ctrl.sv */
// sequencing state machine: accept, execute, slot-by-slot claim scan
module wsrr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  wsrr_pkg::dp_sts_t  sts_i,
  output wsrr_pkg::ctrl_cmd_t cmd_o
);
  import wsrr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.mode == MODE_CLAIM) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN_RD;
        end else if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          if (sts_i.out_free) begin
            cmd_o.claim_miss = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (sts_i.slot_live) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCAN_CK;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SCAN_CK: begin
        if (sts_i.slot_ok) begin
          // hold here until the output register frees up
          if (sts_i.out_free) begin
            cmd_o.claim_hit = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/wsrr_dp.sv */
// datapath: slot table, active and registered bits, counters, config and result register
module wsrr_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [wsrr_pkg::MODE_W-1:0]           in_mode_i,
  input  logic [wsrr_pkg::IN_TDATA_W-1:0]       in_data_i,
  input  logic                                  cfg_we_i,
  input  logic [wsrr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wsrr_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  input  wsrr_pkg::ctrl_cmd_t                   cmd_i,
  output wsrr_pkg::dp_sts_t                     sts_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [wsrr_pkg::OUT_TDATA_W-1:0]      out_data_o
);
  import wsrr_pkg::*;

  // captured word
  mode_e              mode_q;
  logic [SLOT_W-1:0]  slot_q;
  slot_entry_t        ent_q;

  // worker config
  logic [TS_W-1:0]         wmax_q;
  logic signed [DOM_W-1:0] wdom_q;

  logic [NUM_SLOTS-1:0] act_q, act_d;
  logic [NUM_SLOTS-1:0] reg_q, reg_d;
  logic [CNT_W-1:0]     assigned_q, assigned_d;
  logic [CNT_W-1:0]     ss_q, ss_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic [SLOT_W-1:0]    c_q, c_d;
  logic [CNT_W-1:0]     k_q, k_d;

  slot_entry_t mem [NUM_SLOTS];
  slot_entry_t rd_q;
  logic        mem_we;

  logic                 out_valid_q;
  logic [SLOT_W-1:0]    out_slot_q;
  status_e              out_status_q;
  logic [CNT_W-1:0]     out_count_q;

  logic [SLOT_W-1:0]    res_slot;
  status_e              res_status;
  logic                 out_load;
  logic                 full;
  logic [SLOT_W-1:0]    an;
  logic [SLOT_W-1:0]    scan_start;
  logic [CNT_W-1:0]     c_inc;
  logic                 bad_ts, bad_dom;

  assign full       = (assigned_q == CNT_W'(NUM_SLOTS));
  assign an         = assigned_q[SLOT_W-1:0];
  assign scan_start = (ss_q < assigned_q) ? ss_q[SLOT_W-1:0] : '0;
  assign c_inc      = {1'b0, c_q} + CNT_W'(1);

  // eligibility of the entry just read
  assign bad_ts  = (wmax_q != '0) && (rd_q.ts != '0) && (wmax_q < rd_q.ts);
  assign bad_dom = !wdom_q[DOM_W-1] && !rd_q.dom[DOM_W-1] && (wdom_q != rd_q.dom);

  assign sts_o.mode      = mode_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.scan_end  = (k_q == assigned_q);
  assign sts_o.slot_live = act_q[c_q] & reg_q[c_q];
  assign sts_o.slot_ok   = !bad_ts && !bad_dom;

  assign out_load = cmd_i.exec | cmd_i.claim_hit | cmd_i.claim_miss;

  always_comb begin
    act_d      = act_q;
    reg_d      = reg_q;
    assigned_d = assigned_q;
    ss_d       = ss_q;
    total_d    = total_q;
    c_d        = c_q;
    k_d        = k_q;
    res_slot   = '0;
    res_status = ST_OK;
    mem_we     = 1'b0;

    if (cmd_i.exec) begin
      unique case (mode_q)
        MODE_REG: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            reg_d[an]  = 1'b1;
            act_d[an]  = 1'b0;
            assigned_d = assigned_q + CNT_W'(1);
            res_slot   = an;
            mem_we     = 1'b1;
          end
        end
        MODE_ADV: begin
          if (!reg_q[slot_q]) begin
            res_status = ST_NO_WORK;
          end else if (act_q[slot_q]) begin
            res_status = ST_ALREADY;
          end else begin
            act_d[slot_q] = 1'b1;
            total_d       = total_q + CNT_W'(1);
          end
        end
        MODE_REL: begin
          if (reg_q[slot_q]) begin
            if (act_q[slot_q]) begin
              act_d[slot_q] = 1'b0;
              total_d       = total_q - CNT_W'(1);
            end
            reg_d[slot_q] = 1'b0;
          end
        end
        MODE_CLAIM: begin
          // claims run through the scan commands
        end
        default: ;
      endcase
    end

    if (cmd_i.scan_init) begin
      c_d = scan_start;
      k_d = '0;
    end

    if (cmd_i.scan_step) begin
      k_d = k_q + CNT_W'(1);
      c_d = (c_inc == assigned_q) ? '0 : c_inc[SLOT_W-1:0];
    end

    if (cmd_i.claim_hit) begin
      act_d[c_q] = 1'b0;
      total_d    = total_q - CNT_W'(1);
      ss_d       = c_inc;
      res_slot   = c_q;
    end

    if (cmd_i.claim_miss) begin
      res_status = ST_NO_WORK;
      ss_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= '0;
      reg_q       <= '0;
      assigned_q  <= '0;
      ss_q        <= '0;
      total_q     <= '0;
      c_q         <= '0;
      k_q         <= '0;
      mode_q      <= MODE_REG;
      wmax_q      <= '0;
      wdom_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      act_q      <= act_d;
      reg_q      <= reg_d;
      assigned_q <= assigned_d;
      ss_q       <= ss_d;
      total_q    <= total_d;
      c_q        <= c_d;
      k_q        <= k_d;
      if (cmd_i.capture) begin
        mode_q <= mode_e'(in_mode_i);
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAX_TS: wmax_q <= cfg_data_i[TS_W-1:0];
          CFG_DOMAIN: wdom_q <= cfg_data_i[DOM_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q    <= in_data_i[IN_SLOT_LSB +: SLOT_W];
      ent_q.dom <= in_data_i[IN_DOM_LSB +: DOM_W];
      ent_q.ts  <= in_data_i[IN_TS_LSB +: TS_W];
    end
    if (out_load) begin
      out_slot_q   <= res_slot;
      out_status_q <= res_status;
      out_count_q  <= total_d;
    end
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[an] <= ent_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[c_q];
    end
  end

  assign out_valid_o = out_valid_q;
  always_comb begin
    out_data_o = '0;
    out_data_o[OUT_SLOT_LSB +: SLOT_W]  = out_slot_q;
    out_data_o[OUT_STS_LSB +: STATUS_W] = out_status_q;
    out_data_o[OUT_CNT_LSB +: CNT_W]    = out_count_q;
  end

endmodule

/* sv/wsrr_checker.sv */
// port-level checks for the dispatcher top level, bound in below
module wsrr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [wsrr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import wsrr_pkg::*;

  logic [SLOT_W-1:0]   o_slot;
  logic [STATUS_W-1:0] o_sts;
  logic [CNT_W-1:0]    o_cnt;

  assign o_slot = m_axis_tdata[OUT_SLOT_LSB +: SLOT_W];
  assign o_sts  = m_axis_tdata[OUT_STS_LSB +: STATUS_W];
  assign o_cnt  = m_axis_tdata[OUT_CNT_LSB +: CNT_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no acceptance right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on back-to-back cycles");

  // failed items report slot zero
  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (o_sts != ST_OK) |-> (o_slot == '0))
    else $error("nonzero slot with failing status");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_cnt <= CNT_W'(NUM_SLOTS)))
    else $error("active count above slot count");

  // an already-advertised slot is counted as active
  a_already_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (o_sts == ST_ALREADY) |-> (o_cnt != '0))
    else $error("already advertised with zero active count");

endmodule

bind work_slot_round_robin_dispatcher_top wsrr_checker u_wsrr_checker (.*);
